@@ sv/rwcp_pkg.sv @@
// rwcp_pkg: shared constants, codes and control structs of the RIFF/WAVE chunk parser.
// No dependencies; every module file of the block imports it, but rwcp_intf does not.
package rwcp_pkg;

    // Four-character codes as they assemble little-endian from the byte stream
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam int unsigned MS_PER_S = 1000;

    // duration divider: 32-bit length times 1000 needs 42 bits
    localparam int unsigned NUM_W     = 42;
    localparam int unsigned DIV_STEPS = NUM_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // result queue
    localparam int unsigned RESQ_DEPTH = 4;
    localparam int unsigned RESQ_PTR_W = $clog2(RESQ_DEPTH);
    localparam int unsigned RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_RIFF  = 3'd1,
        ST_NOT_WAVE  = 3'd2,
        ST_SIZE      = 3'd3,
        ST_NO_DATA   = 3'd4,
        ST_TRUNC     = 3'd5,
        ST_ZERO_RATE = 3'd6
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        t_status     status;
    } t_res_entry;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic shift;
        logic set_walk_end;
        logic set_chunk_id;
        logic set_len;
        logic walk_one;
        logic walk_four;
        logic count_down;
        logic fmt_write;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic word_is_riff;
        logic word_is_wave;
        logic word_zero;
        logic word_eq_buf;
        logic id_is_data;
        logic id_is_fmt;
        logic walk_ok;
        logic rem_is_one;
        logic odd_pad;
        logic bps_zero;
    } t_dp_stat;

    // result queue -> controller
    typedef struct packed {
        logic room1;
        logic room2;
        logic has_summary;
    } t_q_stat;

endpackage

@@ sv/rwcp_intf.sv @@
// rwcp_intf: valid/ready channel interfaces of the RIFF/WAVE chunk parser.
// Depends on nothing; the field widths follow the block's port list.
interface rwcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_first;
    logic       in_last;

    modport source (output valid, output in_byte, output in_first, output in_last,
                    input ready);
    modport sink   (input valid, input in_byte, input in_first, input in_last,
                    output ready);
endinterface

interface rwcp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] bytes_per_second;
    logic [15:0] frame_align;
    logic [15:0] sample_bits;
    logic [31:0] data_bytes;
    logic [31:0] duration_ms;
    logic        is_last;

    modport source (output valid, output out_kind, output payload_byte, output status,
                    output format_tag, output channel_count, output sample_rate,
                    output bytes_per_second, output frame_align, output sample_bits,
                    output data_bytes, output duration_ms, output is_last,
                    input ready);
    modport sink   (input valid, input out_kind, input payload_byte, input status,
                    input format_tag, input channel_count, input sample_rate,
                    input bytes_per_second, input frame_align, input sample_bits,
                    input data_bytes, input duration_ms, input is_last,
                    output ready);
endinterface

interface rwcp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] buffer_length;

    modport source (output valid, output buffer_length, input ready);
    modport sink   (input valid, input buffer_length, output ready);
endinterface

@@ sv/rwcp_div.sv @@
// rwcp_div: restoring divider for the duration, (buffer_length * 1000) / bytes_per_second.
// One quotient bit per cycle; depends on rwcp_pkg.
module rwcp_div import rwcp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_buffer_length,
    input  logic [31:0]      i_bps,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quotient
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_num;   // dividend shifts out, quotient shifts in
    logic [31:0]          r_rem;

    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_ge;

    always_comb begin
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_diff  = w_trial - {1'b0, i_bps};
        w_ge    = w_trial >= {1'b0, i_bps};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            r_num  <= NUM_W'(i_buffer_length) * NUM_W'(MS_PER_S);
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_num;

endmodule

@@ sv/rwcp_dp.sv @@
// rwcp_dp: parser datapath - field shifter, chunk counters, walk check, fmt words, config.
// Driven by rwcp_ctrl commands; depends on rwcp_pkg.
module rwcp_dp import rwcp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_byte,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_data,
    output logic [31:0]      o_buffer_length,
    output logic [3:0][31:0] o_format_words
);

    logic [31:0]       r_field_shift;
    logic [31:0]       r_chunk_id;
    logic [31:0]       r_chunk_rem;
    logic [31:0]       r_walked;
    logic [31:0]       r_walk_end;
    logic [3:0][31:0]  r_format;
    logic              r_odd_pad;
    logic [31:0]       r_buffer_length;

    logic [31:0] w_shift_base;
    logic [31:0] w_word;
    logic [31:0] w_walk_add;
    logic [31:0] w_n_walked;
    logic [1:0]  w_fmt_w;
    logic [1:0]  w_fmt_b;

    always_comb begin
        w_shift_base = i_cmd.clear ? 32'd0 : r_field_shift;
        w_word       = {i_byte, w_shift_base[31:8]};
        w_walk_add   = i_cmd.walk_four ? 32'd4 : (i_cmd.walk_one ? 32'd1 : 32'd0);
        w_n_walked   = (i_cmd.clear ? 32'd0 : r_walked) + w_walk_add;
        w_fmt_w      = r_field_shift[3:2];
        w_fmt_b      = r_field_shift[1:0];
    end

    always_comb begin
        o_stat.word_is_riff = w_word == TAG_RIFF;
        o_stat.word_is_wave = w_word == TAG_WAVE;
        o_stat.word_zero    = w_word == 32'd0;
        o_stat.word_eq_buf  = w_word == r_buffer_length;
        o_stat.id_is_data   = r_chunk_id == TAG_DATA;
        o_stat.id_is_fmt    = r_chunk_id == TAG_FMT;
        o_stat.walk_ok      = w_n_walked < r_walk_end;
        o_stat.rem_is_one   = r_chunk_rem == 32'd1;
        o_stat.odd_pad      = r_odd_pad;
        o_stat.bps_zero     = r_format[2] == 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_shift   <= '0;
            r_chunk_id      <= '0;
            r_chunk_rem     <= '0;
            r_walked        <= '0;
            r_walk_end      <= '0;
            r_format        <= '0;
            r_odd_pad       <= 1'b0;
            r_buffer_length <= '0;
        end else begin
            if (i_cfg_we) begin
                r_buffer_length <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_field_shift <= '0;
                r_chunk_id    <= '0;
                r_chunk_rem   <= '0;
                r_walked      <= '0;
                r_walk_end    <= '0;
                r_format      <= '0;
                r_odd_pad     <= 1'b0;
            end
            if (i_cmd.shift) begin
                r_field_shift <= w_word;
            end
            if (i_cmd.set_walk_end) begin
                r_walk_end <= w_word - 32'd4;   // wraps for a length below four
            end
            if (i_cmd.set_chunk_id) begin
                r_chunk_id <= w_word;
            end
            if (i_cmd.walk_one || i_cmd.walk_four) begin
                r_walked <= w_n_walked;
            end
            if (i_cmd.set_len) begin
                r_chunk_rem   <= w_word;
                r_odd_pad     <= w_word[0];
                r_field_shift <= '0;            // becomes the fmt body offset
            end
            if (i_cmd.count_down) begin
                r_chunk_rem <= r_chunk_rem - 32'd1;
            end
            if (i_cmd.fmt_write) begin
                if (r_field_shift < 32'd16) begin
                    r_format[w_fmt_w][{w_fmt_b, 3'b000} +: 8] <= i_byte;
                end
                r_field_shift <= r_field_shift + 32'd1;
            end
        end
    end

    assign o_buffer_length = r_buffer_length;
    assign o_format_words  = r_format;

endmodule

@@ sv/rwcp_resq.sv @@
// rwcp_resq: four-entry result queue; takes up to two results per cycle, gives one.
// Depends on rwcp_pkg.
module rwcp_resq import rwcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push0,
    input  logic       i_push1,
    input  t_res_entry i_entry0,
    input  t_res_entry i_entry1,
    input  logic       i_pop,
    output logic       o_valid,
    output t_res_entry o_head,
    output t_q_stat    o_stat
);

    t_res_entry            r_mem [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] r_wr;
    logic [RESQ_PTR_W-1:0] r_rd;
    logic [RESQ_CNT_W-1:0] r_count;
    logic                  r_has_sum;

    logic [RESQ_CNT_W-1:0] n_count;
    logic [RESQ_PTR_W-1:0] w_wr1;
    logic                  w_pop;

    always_comb begin
        w_pop   = i_pop && (r_count != '0);
        w_wr1   = r_wr + RESQ_PTR_W'(1);
        n_count = r_count + RESQ_CNT_W'(i_push0) + RESQ_CNT_W'(i_push1)
                - RESQ_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr] <= i_entry0;
        end
        if (i_push1) begin
            r_mem[w_wr1] <= i_entry1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= '0;
            r_rd      <= '0;
            r_count   <= '0;
            r_has_sum <= 1'b0;
        end else begin
            r_wr    <= r_wr + RESQ_PTR_W'(i_push0) + RESQ_PTR_W'(i_push1);
            r_count <= n_count;
            if (w_pop) begin
                r_rd <= r_rd + RESQ_PTR_W'(1);
            end
            if (i_push0 && (i_entry0.kind == KIND_SUMMARY)) begin
                r_has_sum <= 1'b1;
            end else if (w_pop && (o_head.kind == KIND_SUMMARY)) begin
                r_has_sum <= 1'b0;
            end
        end
    end

    always_comb begin
        o_valid            = r_count != '0;
        o_head             = r_mem[r_rd];
        o_stat.room1       = r_count != RESQ_CNT_W'(RESQ_DEPTH);
        o_stat.room2       = r_count <= RESQ_CNT_W'(RESQ_DEPTH - 2);
        o_stat.has_summary = r_has_sum;
    end

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push1 |-> i_push0)
        else $error("second result pushed without a first");
    a_room_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push1 |-> (r_count <= RESQ_CNT_W'(RESQ_DEPTH - 2)))
        else $error("double push into a queue without two free entries");
    a_room_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push0 |-> (r_count != RESQ_CNT_W'(RESQ_DEPTH)))
        else $error("push into a full result queue");

endmodule

@@ sv/rwcp_ctrl.sv @@
// rwcp_ctrl: parse-phase state machine; issues datapath commands and result pushes.
// Depends on rwcp_pkg; works with rwcp_dp, rwcp_resq and rwcp_div.
module rwcp_ctrl import rwcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_first,
    input  logic       i_in_last,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    input  t_q_stat    i_q_stat,
    output logic       o_push0,
    output logic       o_push1,
    output t_res_entry o_entry0,
    output t_res_entry o_entry1,
    output logic       o_div_start,
    input  logic       i_div_busy
);

    typedef enum logic [3:0] {
        PH_RIFF, PH_RLEN, PH_WAVE, PH_CID, PH_CLEN,
        PH_FMT, PH_SKIP, PH_DATA, PH_PAD, PH_DONE
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [1:0] r_idx, n_idx;
    logic       r_sum_pend, n_sum_pend;

    t_phase     w_phase;
    logic [1:0] w_idx;
    logic       w_fire;
    logic       w_begin;
    logic       w_summary;
    logic       w_err;
    t_status    w_err_code;
    logic       w_trunc;
    logic       w_payload;
    t_res_entry w_e_pay;
    t_res_entry w_e_err;

    always_comb begin
        o_in_ready = i_q_stat.room2 && !r_sum_pend && !i_q_stat.has_summary;
        w_fire     = i_in_valid && o_in_ready;
        w_phase    = i_in_first ? PH_RIFF : r_phase;
        w_idx      = i_in_first ? 2'd0 : r_idx;

        n_phase     = r_phase;
        n_idx       = r_idx;
        n_sum_pend  = r_sum_pend;
        o_cmd       = '0;
        o_div_start = 1'b0;
        w_begin     = 1'b0;
        w_summary   = 1'b0;
        w_err       = 1'b0;
        w_err_code  = ST_OK;
        w_trunc     = 1'b0;
        w_payload   = 1'b0;

        if (w_fire) begin
            o_cmd.clear = i_in_first;
            n_phase     = w_phase;
            n_idx       = w_idx;
            case (w_phase)
                PH_RIFF, PH_RLEN, PH_WAVE, PH_CID, PH_CLEN: begin
                    o_cmd.shift = 1'b1;
                    if (w_idx != 2'd3) begin
                        n_idx = w_idx + 2'd1;
                    end else begin
                        n_idx = 2'd0;
                        case (w_phase)
                            PH_RIFF: begin
                                if (i_stat.word_is_riff) begin
                                    n_phase = PH_RLEN;
                                end else begin
                                    w_err      = 1'b1;
                                    w_err_code = ST_NOT_RIFF;
                                end
                            end
                            PH_RLEN: begin
                                o_cmd.set_walk_end = 1'b1;
                                n_phase            = PH_WAVE;
                            end
                            PH_WAVE: begin
                                if (i_stat.word_is_wave) begin
                                    w_begin = 1'b1;
                                end else begin
                                    w_err      = 1'b1;
                                    w_err_code = ST_NOT_WAVE;
                                end
                            end
                            PH_CID: begin
                                o_cmd.set_chunk_id = 1'b1;
                                o_cmd.walk_four    = 1'b1;
                                n_phase            = PH_CLEN;
                            end
                            default: begin
                                // chunk length word
                                o_cmd.walk_four = 1'b1;
                                o_cmd.set_len   = 1'b1;
                                if (i_stat.id_is_data) begin
                                    if (!i_stat.word_eq_buf) begin
                                        w_err      = 1'b1;
                                        w_err_code = ST_SIZE;
                                    end else if (i_stat.word_zero) begin
                                        w_summary = 1'b1;
                                    end else begin
                                        n_phase = PH_DATA;
                                    end
                                end else if (i_stat.word_zero) begin
                                    w_begin = 1'b1;     // even length, no pad
                                end else begin
                                    n_phase = i_stat.id_is_fmt ? PH_FMT : PH_SKIP;
                                end
                            end
                        endcase
                    end
                end
                PH_FMT, PH_SKIP: begin
                    o_cmd.fmt_write  = w_phase == PH_FMT;
                    o_cmd.walk_one   = 1'b1;
                    o_cmd.count_down = 1'b1;
                    if (i_stat.rem_is_one) begin
                        if (i_stat.odd_pad) begin
                            n_phase = PH_PAD;
                        end else begin
                            w_begin = 1'b1;
                        end
                    end
                end
                PH_DATA: begin
                    w_payload        = 1'b1;
                    o_cmd.walk_one   = 1'b1;
                    o_cmd.count_down = 1'b1;
                    if (i_stat.rem_is_one) begin
                        w_summary = 1'b1;
                    end
                end
                PH_PAD: begin
                    o_cmd.walk_one = 1'b1;
                    w_begin        = 1'b1;
                end
                PH_DONE: begin
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase

            // next chunk header, if the walk has room for it
            if (w_begin) begin
                if (i_stat.walk_ok) begin
                    n_phase = PH_CID;
                    n_idx   = 2'd0;
                end else begin
                    w_err      = 1'b1;
                    w_err_code = ST_NO_DATA;
                end
            end
            if (w_summary) begin
                if (i_stat.bps_zero) begin
                    w_err      = 1'b1;
                    w_err_code = ST_ZERO_RATE;
                end else begin
                    o_div_start = 1'b1;
                    n_sum_pend  = 1'b1;
                    n_phase     = PH_DONE;
                end
            end
            if (w_err) begin
                n_phase = PH_DONE;
            end
            if (i_in_last && (n_phase != PH_DONE)) begin
                w_trunc = 1'b1;
                n_phase = PH_DONE;
            end
        end

        w_e_pay.kind   = KIND_PAYLOAD;
        w_e_pay.data   = i_in_byte;
        w_e_pay.status = ST_OK;
        w_e_err.kind   = KIND_ERROR;
        w_e_err.data   = 8'd0;
        w_e_err.status = w_trunc ? ST_TRUNC : w_err_code;

        o_push0  = 1'b0;
        o_push1  = 1'b0;
        o_entry0 = w_e_pay;
        o_entry1 = w_e_err;
        if (w_payload) begin
            o_push0 = 1'b1;
            o_push1 = w_err || w_trunc;
        end else if (w_err || w_trunc) begin
            o_push0  = 1'b1;
            o_entry0 = w_e_err;
        end else if (!w_fire && r_sum_pend && !i_div_busy && i_q_stat.room1) begin
            o_push0         = 1'b1;
            o_entry0.kind   = KIND_SUMMARY;
            o_entry0.data   = 8'd0;
            o_entry0.status = ST_OK;
            n_sum_pend      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RIFF;
            r_idx      <= 2'd0;
            r_sum_pend <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_sum_pend <= n_sum_pend;
        end
    end

    a_sum_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum_pend && i_div_busy) |=> r_sum_pend)
        else $error("pending summary dropped while the divider runs");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_start |=> ((r_phase == PH_DONE) && r_sum_pend))
        else $error("division started without ending the parse");
    a_quiet_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !i_in_first && (r_phase == PH_DONE)) |-> !o_push0)
        else $error("result produced after the parse ended");

endmodule

@@ sv/riff_wave_chunk_parser.sv @@
// riff_wave_chunk_parser: top level of the streaming RIFF/WAVE header parser.
// Depends on rwcp_pkg, rwcp_intf, rwcp_ctrl, rwcp_dp, rwcp_resq and rwcp_div.
//
// Takes a WAV file one byte per transaction on i_in and returns results on
// o_out: one payload result per data-chunk byte, then a format summary, or
// an error that ends the file. Header, chunk and data bytes are taken one per
// cycle; a byte may queue up to two results (a payload and an error) in a
// four-entry result queue, and input stalls while fewer than two entries are
// free. The summary needs bytes_per_second into data_bytes * 1000, worked out
// by a restoring divider at one quotient bit per cycle; while it runs, and until
// the summary it yields has been queued and then taken, no byte is accepted.
// in_first restarts parsing at any byte; after a
// summary or error, bytes are taken and dropped until the next in_first.
// buffer_length on i_cfg (always ready) is the expected data-chunk length; write
// it only while the parser is idle. No clearing pass follows reset.
module riff_wave_chunk_parser import rwcp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    rwcp_in_if.sink    i_in,
    rwcp_out_if.source o_out,
    rwcp_cfg_if.sink   i_cfg
);

    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    t_q_stat          w_q_stat;
    logic             w_push0;
    logic             w_push1;
    t_res_entry       w_entry0;
    t_res_entry       w_entry1;
    logic             w_q_valid;
    t_res_entry       w_head;
    logic             w_div_start;
    logic             w_div_busy;
    logic [NUM_W-1:0] w_quotient;
    logic [31:0]      w_buffer_length;
    logic [3:0][31:0] w_fmt;
    logic             w_is_sum;

    assign i_cfg.ready = 1'b1;

    rwcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_in_byte   (i_in.in_byte),
        .i_in_first  (i_in.in_first),
        .i_in_last   (i_in.in_last),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .i_q_stat    (w_q_stat),
        .o_push0     (w_push0),
        .o_push1     (w_push1),
        .o_entry0    (w_entry0),
        .o_entry1    (w_entry1),
        .o_div_start (w_div_start),
        .i_div_busy  (w_div_busy)
    );

    rwcp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte          (i_in.in_byte),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_data      (i_cfg.buffer_length),
        .o_buffer_length (w_buffer_length),
        .o_format_words  (w_fmt)
    );

    // fmt words: [0] tag/channels, [1] sample rate, [2] bytes/s, [3] align/bits
    rwcp_div u_div (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_div_start),
        .i_buffer_length (w_buffer_length),
        .i_bps           (w_fmt[2]),
        .o_busy          (w_div_busy),
        .o_quotient      (w_quotient)
    );

    rwcp_resq u_resq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push0  (w_push0),
        .i_push1  (w_push1),
        .i_entry0 (w_entry0),
        .i_entry1 (w_entry1),
        .i_pop    (o_out.ready),
        .o_valid  (w_q_valid),
        .o_head   (w_head),
        .o_stat   (w_q_stat)
    );

    // Summary fields are read live from the fmt words and the divider; both
    // hold still while a summary waits, since input is stalled until it goes.
    always_comb begin
        w_is_sum               = w_head.kind == KIND_SUMMARY;
        o_out.valid            = w_q_valid;
        o_out.out_kind         = w_head.kind;
        o_out.payload_byte     = w_head.data;
        o_out.status           = w_head.status;
        o_out.is_last          = w_head.kind != KIND_PAYLOAD;
        o_out.format_tag       = w_is_sum ? w_fmt[0][15:0]  : 16'd0;
        o_out.channel_count    = w_is_sum ? w_fmt[0][31:16] : 16'd0;
        o_out.sample_rate      = w_is_sum ? w_fmt[1]        : 32'd0;
        o_out.bytes_per_second = w_is_sum ? w_fmt[2]        : 32'd0;
        o_out.frame_align      = w_is_sum ? w_fmt[3][15:0]  : 16'd0;
        o_out.sample_bits      = w_is_sum ? w_fmt[3][31:16] : 16'd0;
        o_out.data_bytes       = w_is_sum ? w_buffer_length : 32'd0;
        if (!w_is_sum) begin
            o_out.duration_ms = 32'd0;
        end else if (w_quotient[NUM_W-1:32] != '0) begin
            o_out.duration_ms = 32'hFFFF_FFFF;     // saturate
        end else begin
            o_out.duration_ms = w_quotient[31:0];
        end
    end

endmodule
